>>> rtl/core/rap_pkg.sv
// ----------------------------------------------------------------------------
// RADIUS attribute parser package
// Shared constants, status codes and record types.
// ----------------------------------------------------------------------------
package rap_pkg;

    localparam int unsigned MAX_PACKET   = 4096;
    localparam int unsigned MIN_PACKET   = 20;
    localparam int unsigned HEADER_BYTES = 20;

    localparam logic [12:0] POS_MAX = 13'd8191;

    localparam logic [7:0] TYPE_PASSWORD   = 8'd2;
    localparam logic [7:0] TYPE_VENDOR     = 8'd26;
    localparam logic [7:0] CODE_ACCESS_REQ = 8'd1;

    localparam logic KIND_ATTR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SIZE        = 3'd1;
    localparam logic [2:0] ST_LEN_MISMATCH = 3'd2;
    localparam logic [2:0] ST_SHORT_ATTR  = 3'd3;
    localparam logic [2:0] ST_OVERRUN     = 3'd4;
    localparam logic [2:0] ST_SHORT_VSA   = 3'd5;
    localparam logic [2:0] ST_PWD_CODE    = 3'd6;
    localparam logic [2:0] ST_PWD_LEN     = 3'd7;

    // result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        record_kind;
        logic [7:0]  attr_type;
        logic [31:0] vendor_id;
        logic [11:0] value_offset;
        logic [7:0]  value_length;
        logic [7:0]  packet_code;
        logic [7:0]  packet_id;
        logic [15:0] packet_length;
        logic [2:0]  status;
        logic        last_of_item;
    } rec_t;

    // records produced by one request, r0 first
    typedef struct packed {
        logic [1:0] n;
        rec_t       r0;
        rec_t       r1;
    } push_t;

endpackage

>>> rtl/core/radius_attribute_parser_core.sv
// ----------------------------------------------------------------------------
// RADIUS attribute parser core
// A record enters the result queue when its octet is accepted; m_ reads it out.
// Throughput: one octet per cycle while the queue has room; an octet that yields
// an attribute and a status record pushes both at once (4-entry queue).
// Reset: synchronous active-low aresetn clears parse state and the queue.
// ----------------------------------------------------------------------------
module radius_attribute_parser_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_end,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_record_kind,
    output logic [7:0]  m_attr_type,
    output logic [31:0] m_vendor_id,
    output logic [11:0] m_value_offset,
    output logic [7:0]  m_value_length,
    output logic [7:0]  m_packet_code,
    output logic [7:0]  m_packet_id,
    output logic [15:0] m_packet_length,
    output logic [2:0]  m_status,
    output logic        m_last_of_item
);

    logic           accept;
    logic           room;
    rap_pkg::push_t push;
    rap_pkg::rec_t  rec;

    assign s_ready = room;
    assign accept  = s_valid && room;

    rap_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (accept),
        .in_byte  (s_rx_byte),
        .in_end   (s_frame_end),
        .push     (push)
    );

    rap_rec_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rec   (rec)
    );

    assign m_record_kind   = rec.record_kind;
    assign m_attr_type     = rec.attr_type;
    assign m_vendor_id     = rec.vendor_id;
    assign m_value_offset  = rec.value_offset;
    assign m_value_length  = rec.value_length;
    assign m_packet_code   = rec.packet_code;
    assign m_packet_id     = rec.packet_id;
    assign m_packet_length = rec.packet_length;
    assign m_status        = rec.status;
    assign m_last_of_item  = rec.last_of_item;

endmodule

>>> rtl/core/rap_parse.sv
// ----------------------------------------------------------------------------
// RADIUS attribute parser - byte walker
// Header capture, TLV walk, checks and record generation per octet.
// ----------------------------------------------------------------------------
module rap_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              in_end,
    output rap_pkg::push_t    push
);

    logic [12:0] pos_reg,    pos_next;
    logic [7:0]  code_reg,   code_next;
    logic [7:0]  id_reg,     id_next;
    logic [15:0] len_reg,    len_next;
    logic [12:0] start_reg,  start_next;
    logic [7:0]  type_reg,   type_next;
    logic [7:0]  alen_reg,   alen_next;
    logic [31:0] vendor_reg, vendor_next;
    logic [2:0]  err_reg,    err_next;

    logic          walk;
    logic          emit;
    logic [13:0]   s_plus1;
    logic [12:0]   off;
    logic [13:0]   count;
    logic [2:0]    st;
    rap_pkg::rec_t attr_rec;
    rap_pkg::rec_t stat_rec;

    always_comb begin
        pos_next    = pos_reg;
        code_next   = code_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        start_next  = start_reg;
        type_next   = type_reg;
        alen_next   = alen_reg;
        vendor_next = vendor_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        s_plus1     = {1'b0, start_reg} + 14'd1;
        off         = pos_reg - start_reg;
        count       = {1'b0, pos_reg} + 14'd1;
        st          = rap_pkg::ST_OK;
        attr_rec    = '0;
        stat_rec    = '0;

        if (pos_reg == 13'd0) begin
            code_next  = in_byte;
            start_next = 13'(rap_pkg::HEADER_BYTES);
        end else if (pos_reg == 13'd1) begin
            id_next = in_byte;
        end else if (pos_reg == 13'd2) begin
            len_next = {in_byte, len_reg[7:0]};
        end else if (pos_reg == 13'd3) begin
            len_next = {len_reg[15:8], in_byte};
        end

        walk = (err_reg == rap_pkg::ST_OK)
            && (pos_reg >= 13'(rap_pkg::HEADER_BYTES))
            && ({3'b0, pos_reg} < len_reg)
            && (pos_reg < 13'(rap_pkg::MAX_PACKET));

        if (walk) begin
            if (pos_reg == start_reg) begin
                type_next   = in_byte;
                alen_next   = 8'd0;
                vendor_next = 32'd0;
                if (({4'b0, pos_reg} + 17'd1) >= {1'b0, len_reg}) begin
                    err_next = rap_pkg::ST_OVERRUN;
                end
            end else if ({1'b0, pos_reg} == s_plus1) begin
                alen_next = in_byte;
                if (in_byte < 8'd2) begin
                    err_next = rap_pkg::ST_SHORT_ATTR;
                end else if (({3'b0, start_reg} + {8'b0, in_byte}) > len_reg) begin
                    err_next = rap_pkg::ST_OVERRUN;
                end else if (type_reg == rap_pkg::TYPE_VENDOR && in_byte <= 8'd8) begin
                    err_next = rap_pkg::ST_SHORT_VSA;
                end else if (type_reg == rap_pkg::TYPE_PASSWORD
                             && code_reg != rap_pkg::CODE_ACCESS_REQ) begin
                    err_next = rap_pkg::ST_PWD_CODE;
                end else if (type_reg == rap_pkg::TYPE_PASSWORD
                             && in_byte[3:0] != 4'd2) begin
                    // (len - 2) mod 16 != 0
                    err_next = rap_pkg::ST_PWD_LEN;
                end else if (in_byte == 8'd2) begin
                    emit = 1'b1;
                end
            end else begin
                if (type_reg == rap_pkg::TYPE_VENDOR && off <= 13'd5) begin
                    vendor_next = {vendor_reg[23:0], in_byte};
                end
                if ((off + 13'd1) == {5'b0, alen_reg}) begin
                    emit = 1'b1;
                end
            end
        end

        attr_rec.record_kind = rap_pkg::KIND_ATTR;
        attr_rec.attr_type   = type_next;
        if (type_next == rap_pkg::TYPE_VENDOR) begin
            attr_rec.vendor_id    = vendor_next;
            attr_rec.value_offset = start_reg[11:0] + 12'd6;
            attr_rec.value_length = alen_next - 8'd6;
        end else begin
            attr_rec.vendor_id    = 32'd0;
            attr_rec.value_offset = start_reg[11:0] + 12'd2;
            attr_rec.value_length = alen_next - 8'd2;
        end
        attr_rec.last_of_item = !in_end;
        if (emit) begin
            start_next = start_reg + {5'b0, alen_next};
        end

        if (pos_reg < rap_pkg::POS_MAX) begin
            pos_next = pos_reg + 13'd1;
        end

        if (count < 14'(rap_pkg::MIN_PACKET) || count > 14'(rap_pkg::MAX_PACKET)) begin
            st = rap_pkg::ST_SIZE;
        end else if ({2'b0, count} != len_next) begin
            st = rap_pkg::ST_LEN_MISMATCH;
        end else begin
            st = err_next;
        end
        stat_rec.record_kind   = rap_pkg::KIND_STATUS;
        stat_rec.packet_code   = code_next;
        stat_rec.packet_id     = id_next;
        stat_rec.packet_length = len_next;
        stat_rec.status        = st;
        stat_rec.last_of_item  = 1'b1;

        if (in_end) begin
            pos_next    = '0;
            code_next   = '0;
            id_next     = '0;
            len_next    = '0;
            start_next  = '0;
            type_next   = '0;
            alen_next   = '0;
            vendor_next = '0;
            err_next    = rap_pkg::ST_OK;
        end

        push.n  = in_valid ? ({1'b0, emit} + {1'b0, in_end}) : 2'd0;
        push.r0 = emit ? attr_rec : stat_rec;
        push.r1 = stat_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            code_reg   <= '0;
            id_reg     <= '0;
            len_reg    <= '0;
            start_reg  <= '0;
            type_reg   <= '0;
            alen_reg   <= '0;
            vendor_reg <= '0;
            err_reg    <= rap_pkg::ST_OK;
        end else if (in_valid) begin
            pos_reg    <= pos_next;
            code_reg   <= code_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            start_reg  <= start_next;
            type_reg   <= type_next;
            alen_reg   <= alen_next;
            vendor_reg <= vendor_next;
            err_reg    <= err_next;
        end
    end

    // first error sticks until frame end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && !in_end && err_reg != rap_pkg::ST_OK) |=> (err_reg == $past(err_reg)))
        else $error("error code changed mid-packet");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_end) |=> (pos_reg == 13'd0 && err_reg == rap_pkg::ST_OK))
        else $error("state not cleared after frame end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n == 2'd2) |-> (push.r0.record_kind == rap_pkg::KIND_ATTR
                              && !push.r0.last_of_item && push.r1.last_of_item))
        else $error("bad record pair ordering");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && walk && pos_reg != start_reg && {1'b0, pos_reg} != s_plus1)
        |-> (pos_reg > start_reg))
        else $error("walk position behind attribute start");

endmodule

>>> rtl/core/rap_rec_fifo.sv
// ----------------------------------------------------------------------------
// RADIUS attribute parser - result queue
// Small record queue taking up to two records per cycle, one out per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module rap_rec_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  rap_pkg::push_t  push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output rap_pkg::rec_t   out_rec
);

    rap_pkg::rec_t mem [rap_pkg::FIFO_DEPTH];

    logic [rap_pkg::PTR_W-1:0] wptr_reg, wptr_next;
    logic [rap_pkg::PTR_W-1:0] rptr_reg, rptr_next;
    logic [rap_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_rec   = mem[rptr_reg];
    assign room      = (count_reg <= rap_pkg::CNT_W'(rap_pkg::FIFO_DEPTH - 2));

    always_comb begin
        wptr_next  = wptr_reg + rap_pkg::PTR_W'(push.n);
        rptr_next  = rptr_reg + rap_pkg::PTR_W'(pop);
        count_next = count_reg + rap_pkg::CNT_W'(push.n) - rap_pkg::CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem[wptr_reg + rap_pkg::PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rap_pkg::CNT_W'(rap_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n != 2'd0) |-> room)
        else $error("push without room");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (wptr_reg - rptr_reg) == count_reg[rap_pkg::PTR_W-1:0])
        else $error("queue pointers and count disagree");

endmodule
